@@ hw/rtl/fnss_pkg.sv @@
// Shared types and register codes for the fixed-needle substring search block.
package fnss_pkg;

  localparam int CHUNK_BYTES = 8;
  localparam int NEEDLE_LIMIT = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_NEEDLE_LOW    = 2'd0;
  localparam logic [1:0] REG_NEEDLE_HIGH   = 2'd1;
  localparam logic [1:0] REG_NEEDLE_LENGTH = 2'd2;

  typedef struct packed {
    logic [63:0] chunk_bytes;
    logic [3:0]  chunk_count;
    logic        chunk_last;
  } fnss_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
    logic        offset_overflow;
  } fnss_out_t;

  // Per-chunk context handed from the lane stage to the merge stage.
  typedef struct packed {
    logic [31:0] pos;
    logic        sat;
    logic        sat_end;
    logic [4:0]  len;
    logic        last;
  } fnss_stage_t;

endpackage

@@ hw/rtl/fnss_lane.sv @@
// One compare lane: checks the window ending at one chunk byte against the needle.
module fnss_lane
  import fnss_pkg::*;
#(
  parameter int LANE_IDX = 0,
  parameter int NCAP     = 16
) (
  input  logic [NCAP*8-1:0] win,
  input  logic [NCAP*8-1:0] needle,
  input  logic [NCAP-1:0]   mask,
  input  logic [4:0]        len,
  input  logic [4:0]        pos_small,
  input  logic              en,
  output logic              hit
);

  logic [NCAP-1:0] byte_ok;
  logic            pos_ok;

  always_comb begin
    for (int j = 0; j < NCAP; j++) begin
      byte_ok[j] = !mask[j] || (win[j*8 +: 8] == needle[j*8 +: 8]);
    end
  end

  // The window is complete once enough haystack bytes precede this one.
  assign pos_ok = ({1'b0, pos_small} + 6'(LANE_IDX) + 6'd1) >= {1'b0, len};
  assign hit    = en && pos_ok && (&byte_ok);

endmodule

@@ hw/rtl/fnss_merge.sv @@
// Merge stage: picks the earliest lane hit, forms the result and holds it for output.
module fnss_merge
  import fnss_pkg::*;
#(
  parameter int LANES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  fnss_stage_t       s1_info,
  input  logic [LANES-1:0]  s1_hits,
  output logic              s1_adv,
  output logic              out_valid,
  input  logic              out_stall,
  output fnss_out_t         out_data
);

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [LW-1:0] first;
  logic          any_hit;
  logic [32:0]   sum;
  logic [31:0]   pos_at;
  logic          emit_found;
  logic          emit_none;
  logic          emit;
  logic          out_free;
  fnss_out_t     res;
  logic          rep_r;
  logic          out_valid_r;
  fnss_out_t     out_data_r;

  always_comb begin
    first = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (s1_hits[i]) begin
        first = LW'(i);
      end
    end
  end

  assign any_hit = |s1_hits;

  // Position of the matching byte, stuck at the top once the counter saturates.
  assign sum    = {1'b0, s1_info.pos} + 33'(first);
  assign pos_at = sum[32] ? '1 : sum[31:0];

  assign emit_found = s1_valid && !rep_r && any_hit;
  assign emit_none  = s1_valid && s1_info.last && !rep_r && !any_hit;
  assign emit       = emit_found || emit_none;
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_adv     = !emit || out_free;

  always_comb begin
    if (emit_found) begin
      res.found           = 1'b1;
      res.match_offset    = pos_at - 32'(s1_info.len - 5'd1);
      res.offset_overflow = s1_info.sat | sum[32];
    end else begin
      res.found           = 1'b0;
      res.match_offset    = '0;
      res.offset_overflow = s1_info.sat_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_valid && s1_adv) begin
        rep_r <= s1_info.last ? 1'b0 : (rep_r | any_hit);
      end
      if (emit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/fixed_needle_substring_search.sv @@
// Top level of the streaming first-occurrence substring search with a configured needle.
//
//   Channel  Direction  Handshake            Carries
//   in_      request    in_valid / in_stall  one haystack chunk (fnss_in_t)
//   out_     result     out_valid/out_stall  found flag, offset, overflow (fnss_out_t)
//   cfg_     write      cfg_valid/cfg_ready  register index and 64-bit data
//
// One chunk is taken every clock while in_stall is low. Lanes compare in the accept
// cycle, the lane stage registers their hits, and the merge stage forms the result
// into the output register that drives out_valid. Reset is synchronous and needs
// no clearing pass. A chunk that must emit while the output register is stalled
// holds the lane stage, and the input then stalls; other chunks keep flowing.
module fixed_needle_substring_search
  import fnss_pkg::*;
#(
  parameter int MAX_NEEDLE_BYTES = 16,
  parameter int LANES            = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  fnss_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output fnss_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NCAP = (MAX_NEEDLE_BYTES < NEEDLE_LIMIT) ? MAX_NEEDLE_BYTES : NEEDLE_LIMIT;
  localparam int HIST = NCAP - 1;

  // Needle registers and the needle realigned so that byte j faces the byte j back.
  logic [63:0]     needle_low_r, needle_high_r;
  logic [4:0]      needle_len_r;
  logic [63:0]     low_nxt, high_nxt;
  logic [4:0]      len_nxt;
  logic [127:0]    needle_all;
  logic [NCAP*8-1:0] aligned_r, aligned_nxt;
  logic [NCAP-1:0] mask_r, mask_nxt;
  logic            len_ok;

  // Haystack state.
  logic [HIST*8-1:0] hist_r, hist_nxt;
  logic [31:0]       pos_r;
  logic              sat_r;
  logic [3:0]        cnt;
  logic [32:0]       pos_sum;
  logic [4:0]        pos_small;
  logic              in_acc;

  logic [NCAP*8-1:0] win [LANES];
  logic [LANES-1:0]  lane_hit;
  logic [7:0]        cand [HIST][LANES+1];

  logic              s1_valid_r;
  fnss_stage_t       s1_info_r;
  logic [LANES-1:0]  s1_hits_r;
  logic              s1_adv;

  assign cfg_ready = 1'b1;

  always_comb begin
    low_nxt  = needle_low_r;
    high_nxt = needle_high_r;
    len_nxt  = needle_len_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_NEEDLE_LOW:    low_nxt  = cfg_data;
        REG_NEEDLE_HIGH:   high_nxt = cfg_data;
        REG_NEEDLE_LENGTH: len_nxt  = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign needle_all = {high_nxt, low_nxt};

  always_comb begin
    logic [4:0] k;
    for (int j = 0; j < NCAP; j++) begin
      k = len_nxt - 5'd1 - 5'(j);
      mask_nxt[j]           = 5'(j) < len_nxt;
      aligned_nxt[j*8 +: 8] = needle_all[k[3:0]*8 +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_low_r  <= '0;
      needle_high_r <= '0;
      needle_len_r  <= 5'd1;
      aligned_r     <= '0;
      mask_r        <= NCAP'(1);
    end else if (cfg_valid) begin
      needle_low_r  <= low_nxt;
      needle_high_r <= high_nxt;
      needle_len_r  <= len_nxt;
      aligned_r     <= aligned_nxt;
      mask_r        <= mask_nxt;
    end
  end

  assign len_ok = (needle_len_r != 5'd0) && (needle_len_r <= 5'(NCAP));

  assign cnt       = (in_data.chunk_count > 4'(LANES)) ? 4'(LANES) : in_data.chunk_count;
  assign pos_sum   = {1'b0, pos_r} + 33'(cnt);
  assign pos_small = (pos_r[31:4] != '0) ? 5'd16 : {1'b0, pos_r[3:0]};
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;

  // Lane windows: the chunk bytes up to this lane, then the kept history.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    for (genvar j = 0; j < NCAP; j++) begin : g_win
      if (j <= i) begin : g_cur
        assign win[i][j*8 +: 8] = in_data.chunk_bytes[(i-j)*8 +: 8];
      end else begin : g_old
        assign win[i][j*8 +: 8] = hist_r[(j-i-1)*8 +: 8];
      end
    end

    fnss_lane #(
      .LANE_IDX (i),
      .NCAP     (NCAP)
    ) u_lane (
      .win       (win[i]),
      .needle    (aligned_r),
      .mask      (mask_r),
      .len       (needle_len_r),
      .pos_small (pos_small),
      .en        (len_ok && (4'(i) < cnt)),
      .hit       (lane_hit[i])
    );
  end

  // History after shifting in the chunk's bytes, one candidate per byte count.
  for (genvar m = 0; m < HIST; m++) begin : g_hist
    for (genvar n = 0; n <= LANES; n++) begin : g_cand
      if (n > m) begin : g_new
        assign cand[m][n] = in_data.chunk_bytes[(n-1-m)*8 +: 8];
      end else begin : g_keep
        assign cand[m][n] = hist_r[(m-n)*8 +: 8];
      end
    end
  end

  always_comb begin
    hist_nxt = hist_r;
    for (int m = 0; m < HIST; m++) begin
      for (int n = 0; n <= LANES; n++) begin
        if (cnt == 4'(n)) begin
          hist_nxt[m*8 +: 8] = cand[m][n];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      sat_r      <= 1'b0;
      hist_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (in_acc) begin
        hist_r <= hist_nxt;
        if (in_data.chunk_last) begin
          pos_r <= '0;
          sat_r <= 1'b0;
        end else begin
          pos_r <= pos_sum[32] ? '1 : pos_sum[31:0];
          sat_r <= sat_r | pos_sum[32];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hits_r         <= lane_hit;
      s1_info_r.pos     <= pos_r;
      s1_info_r.sat     <= sat_r;
      s1_info_r.sat_end <= sat_r | pos_sum[32];
      s1_info_r.len     <= needle_len_r;
      s1_info_r.last    <= in_data.chunk_last;
    end
  end

  fnss_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_info   (s1_info_r),
    .s1_hits   (s1_hits_r),
    .s1_adv    (s1_adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the fixed-needle substring search block.
module tb_top;
  import fnss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_CFG, ROW_CHUNK} row_kind_e;
  typedef enum logic [1:0] {STALL_OFF, STALL_RANDOM, STALL_PERIODIC, STALL_BURSTS} stall_mode_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  reg_index;
    logic [63:0] value;
    logic [3:0]  count;
    logic        last;
    bit          typed;
    fnss_out_t   typed_res;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  fnss_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  fnss_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  fixed_needle_substring_search DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: needle registers and the per-haystack search context.
  logic [63:0] needle_lo;
  logic [63:0] needle_hi;
  logic [4:0]  needle_len;
  logic [7:0]  hist_bytes [NEEDLE_LIMIT-1];
  logic [31:0] hay_pos;
  logic        hay_matched;
  logic        pos_stuck;

  fnss_out_t pending_results [$];
  plan_row_t plan [$];
  logic [7:0] letters [4];
  int nletters;

  int cycle_count = 0;
  int mismatch_count = 0;
  int chunks_sent = 0;
  int results_found = 0;
  int results_missed = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic void clear_haystack();
    foreach (hist_bytes[k]) hist_bytes[k] = 8'h00;
    hay_pos = '0;
    hay_matched = 1'b0;
    pos_stuck = 1'b0;
  endfunction

  // Consumes one chunk request; returns 1 when it produces a result.
  function automatic bit scan_chunk(input fnss_in_t req, output fnss_out_t res);
    logic [127:0] needle;
    logic [7:0]   win [NEEDLE_LIMIT];
    int unsigned  n;
    int unsigned  len;
    bit           hit;
    bit           emits;
    needle = {needle_hi, needle_lo};
    len = 32'(needle_len);
    n = (req.chunk_count > CHUNK_BYTES) ? CHUNK_BYTES : 32'(req.chunk_count);
    res = '0;
    emits = 1'b0;
    for (int i = 0; i < n && !hay_matched; i++) begin
      win[0] = req.chunk_bytes[8*i +: 8];
      for (int k = 1; k < NEEDLE_LIMIT; k++) win[k] = hist_bytes[k-1];
      hit = (len >= 1 && len <= NEEDLE_LIMIT && hay_pos >= len - 1);
      for (int k = 0; k < NEEDLE_LIMIT; k++)
        if (hit && k < len && win[len-1-k] != needle[8*k +: 8]) hit = 1'b0;
      for (int k = 0; k < NEEDLE_LIMIT - 1; k++) hist_bytes[k] = win[k];
      if (hit) begin
        hay_matched = 1'b1;
        res.found = 1'b1;
        res.match_offset = hay_pos - 32'(len - 1);
        res.offset_overflow = pos_stuck;
        emits = 1'b1;
      end
      if (hay_pos == 32'hFFFF_FFFF) pos_stuck = 1'b1;
      else hay_pos = hay_pos + 32'd1;
    end
    if (req.chunk_last) begin
      if (!hay_matched) begin
        res.found = 1'b0;
        res.match_offset = '0;
        res.offset_overflow = pos_stuck;
        emits = 1'b1;
      end
      clear_haystack();
    end
    return emits;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [63:0] val);
    plan_row_t r;
    r = '{kind: ROW_CFG, reg_index: idx, value: val, count: '0, last: 1'b0,
          typed: 1'b0, typed_res: '0};
    return r;
  endfunction

  function automatic plan_row_t chunk_row(input logic [63:0] val, input logic [3:0] cnt,
                                          input logic last);
    plan_row_t r;
    r = '{kind: ROW_CHUNK, reg_index: '0, value: val, count: cnt, last: last,
          typed: 1'b0, typed_res: '0};
    return r;
  endfunction

  function automatic plan_row_t result_row(input logic [63:0] val, input logic [3:0] cnt,
                                           input logic last, input logic hit,
                                           input logic [31:0] offset);
    plan_row_t r;
    r = chunk_row(val, cnt, last);
    r.typed = 1'b1;
    r.typed_res = '{found: hit, match_offset: offset, offset_overflow: 1'b0};
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_chunk(input fnss_in_t req, input bit typed, input fnss_out_t typed_res);
    fnss_out_t res;
    bit emits;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(7, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    emits = scan_chunk(req, res);
    if (typed) pending_results.push_back(typed_res);
    else if (emits) pending_results.push_back(res);
    chunks_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NEEDLE_LOW:    needle_lo = val;
      REG_NEEDLE_HIGH:   needle_hi = val;
      REG_NEEDLE_LENGTH: needle_len = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Lets the block drain: chunks that cause no result may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Builds one haystack and sends it as chunks of random size.
  task automatic send_haystack(inout int sent);
    logic [7:0] hay [$];
    logic [127:0] needle;
    fnss_in_t req;
    int hl;
    int start;
    int idx;
    int take;
    bit noise;
    needle = {needle_hi, needle_lo};
    hl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 48);
    if ($urandom_range(0, 19) == 0) hl = $urandom_range(49, 120);
    noise = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < hl; i++)
      hay.push_back(noise ? 8'($urandom_range(0, 255)) : letters[$urandom_range(0, nletters-1)]);
    if (!noise && $urandom_range(0, 1) == 1) begin
      // Plant a copy of the needle; near the end it gets cut off.
      start = $urandom_range(0, hl);
      for (int k = 0; k < NEEDLE_LIMIT && k < needle_len && start + k < hl; k++)
        hay[start + k] = needle[8*k +: 8];
    end
    idx = 0;
    do begin
      req.chunk_count = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
      take = (req.chunk_count > CHUNK_BYTES) ? CHUNK_BYTES : 32'(req.chunk_count);
      if (take > hay.size() - idx) begin
        take = hay.size() - idx;
        req.chunk_count = 4'(take);
      end
      req.chunk_bytes = {$urandom, $urandom};
      for (int j = 0; j < take; j++) req.chunk_bytes[8*j +: 8] = hay[idx + j];
      idx += take;
      // Now and then the end marker travels alone on an empty chunk.
      req.chunk_last = (idx == hay.size()) && !(take > 0 && $urandom_range(0, 7) == 0);
      send_chunk(req, 1'b0, '0);
      sent++;
    end while (!req.chunk_last);
  endtask

  task automatic pick_phase_setup(input int ph);
    logic [127:0] needle;
    logic [4:0] len;
    nletters = $urandom_range(2, 4);
    foreach (letters[i]) letters[i] = 8'($urandom_range(0, 255));
    case (ph)
      0: len = 5'd1;
      1: len = 5'd16;
      2: len = 5'd0;
      3: len = 5'($urandom_range(17, 31));
      default: len = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(1, 8))
                                                 : 5'($urandom_range(9, 16));
    endcase
    needle = {$urandom, $urandom, $urandom, $urandom};
    for (int k = 0; k < NEEDLE_LIMIT; k++)
      if (k < len && ph != NUM_PHASES - 1) needle[8*k +: 8] = letters[$urandom_range(0, nletters-1)];
    write_reg(REG_NEEDLE_LOW, needle[63:0]);
    write_reg(REG_NEEDLE_HIGH, needle[127:64]);
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
    write_reg(REG_NEEDLE_LENGTH, {$urandom, $urandom} & ~64'h1F | 64'(len));
  endtask

  // Receiver back-pressure: a stall mode is drawn at random for each span of random length.
  initial begin
    stall_mode_e mode;
    int span;
    int hold;
    bit busy;
    out_stall = 1'b0;
    mode = STALL_OFF;
    span = 0;
    hold = 0;
    busy = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(40, 250);
      end
      span--;
      case (mode)
        STALL_OFF:      out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
        STALL_BURSTS: begin
          if (hold == 0) begin
            busy = !busy;
            hold = busy ? $urandom_range(1, 20) : $urandom_range(1, 10);
          end
          hold--;
          out_stall <= busy;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    fnss_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected: found=%0d offset=%0d overflow=%0d",
                 $time, out_data.found, out_data.match_offset, out_data.offset_overflow);
      end else begin
        want = pending_results.pop_front();
        if (want.found) results_found++;
        else results_missed++;
        if (out_data.found !== want.found) begin
          mismatch_count++;
          $display("%0t: found expected %0d actual %0d", $time, want.found, out_data.found);
        end
        if (out_data.match_offset !== want.match_offset) begin
          mismatch_count++;
          $display("%0t: match_offset expected %0d actual %0d", $time,
                   want.match_offset, out_data.match_offset);
        end
        if (out_data.offset_overflow !== want.offset_overflow) begin
          mismatch_count++;
          $display("%0t: offset_overflow expected %0d actual %0d", $time,
                   want.offset_overflow, out_data.offset_overflow);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Run timed out after %0d cycles with %0d results outstanding",
             cycle_count, pending_results.size());
    $display("FAIL fixed_needle_substring_search");
    $finish;
  end

  initial begin
    fnss_in_t req;
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_NEEDLE_LOW;
    cfg_data = '0;
    needle_lo = '0;
    needle_hi = '0;
    needle_len = 5'd1;
    clear_haystack();

    // Directed table. At reset the needle is one zero byte.
    plan.push_back(result_row(64'h0, 4'd0, 1'b1, 1'b0, 32'd0));
    plan.push_back(result_row(64'h0, 4'd1, 1'b1, 1'b1, 32'd0));
    plan.push_back(result_row({64{1'b1}}, 4'd8, 1'b1, 1'b0, 32'd0));
    plan.push_back(cfg_row(REG_NEEDLE_LOW, {64{1'b1}}));
    plan.push_back(cfg_row(REG_NEEDLE_HIGH, {64{1'b1}}));
    plan.push_back(cfg_row(REG_NEEDLE_LENGTH, 64'd16));
    plan.push_back(chunk_row({64{1'b1}}, 4'd8, 1'b0));
    plan.push_back(result_row({64{1'b1}}, 4'd8, 1'b1, 1'b1, 32'd0));
    // An oversized count still only carries eight bytes.
    plan.push_back(chunk_row({64{1'b1}}, 4'd15, 1'b0));
    plan.push_back(result_row({64{1'b1}}, 4'd8, 1'b1, 1'b1, 32'd0));
    plan.push_back(cfg_row(REG_NEEDLE_LENGTH, 64'd0));
    plan.push_back(result_row({64{1'b1}}, 4'd8, 1'b1, 1'b0, 32'd0));
    plan.push_back(cfg_row(REG_NEEDLE_LENGTH, 64'd17));
    plan.push_back(result_row({64{1'b1}}, 4'd8, 1'b1, 1'b0, 32'd0));
    plan.push_back(cfg_row(REG_NEEDLE_LENGTH, {64{1'b1}}));
    plan.push_back(result_row({64{1'b1}}, 4'd8, 1'b1, 1'b0, 32'd0));
    plan.push_back(cfg_row(REG_SPARE, {64{1'b1}}));
    plan.push_back(cfg_row(REG_NEEDLE_LOW, 64'h0000_0000_0063_6261));
    plan.push_back(cfg_row(REG_NEEDLE_HIGH, 64'h0));
    plan.push_back(cfg_row(REG_NEEDLE_LENGTH, 64'd3));
    // The match straddles two chunks.
    plan.push_back(chunk_row(64'h6261_7878_7878_7878, 4'd8, 1'b0));
    plan.push_back(result_row(64'h0000_0000_7878_7863, 4'd4, 1'b1, 1'b1, 32'd6));
    // After a hit the rest of the haystack, last chunk included, is ignored.
    plan.push_back(result_row(64'h0000_0000_0063_6261, 4'd3, 1'b0, 1'b1, 32'd0));
    plan.push_back(chunk_row(64'h0000_0000_0063_6261, 4'd3, 1'b1));
    plan.push_back(chunk_row(64'h0, 4'd0, 1'b0));
    plan.push_back(result_row(64'h0000_0000_0063_6261, 4'd2, 1'b1, 1'b0, 32'd0));
    // History must not carry over from one haystack into the next.
    plan.push_back(result_row(64'h0000_0000_0000_6261, 4'd2, 1'b1, 1'b0, 32'd0));
    plan.push_back(result_row(64'h0000_0000_0000_0063, 4'd1, 1'b1, 1'b0, 32'd0));
    plan.push_back(result_row(64'h0063_6261_0000_0000, 4'd3, 1'b1, 1'b0, 32'd0));
    // A length change in the middle of a haystack applies from the next byte.
    plan.push_back(chunk_row(64'h0000_0000_0000_007a, 4'd1, 1'b0));
    plan.push_back(cfg_row(REG_NEEDLE_LENGTH, 64'd1));
    plan.push_back(chunk_row(64'h0000_0000_0000_0061, 4'd1, 1'b1));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        if (r == 0 || plan[r-1].kind != ROW_CFG) settle();
        write_reg(plan[r].reg_index, plan[r].value);
      end else begin
        req = '{chunk_bytes: plan[r].value, chunk_count: plan[r].count,
                chunk_last: plan[r].last};
        send_chunk(req, plan[r].typed, plan[r].typed_res);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      pick_phase_setup(ph);
      sent = 0;
      while (sent < ((needle_len == 0 || needle_len > NEEDLE_LIMIT) ? 30 : 100))
        send_haystack(sent);
    end

    settle();
    $display("Sent %0d chunk requests over %0d needle settings;", chunks_sent, NUM_PHASES + 6);
    $display("checked %0d found and %0d not-found results, %0d mismatches.",
             results_found, results_missed, mismatch_count);
    if (mismatch_count == 0) $display("PASS fixed_needle_substring_search");
    else $display("FAIL fixed_needle_substring_search");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fnss_pkg.sv
hw/rtl/fnss_lane.sv
hw/rtl/fnss_merge.sv
hw/rtl/fixed_needle_substring_search.sv
verif/tb_top.sv
